FILE: hw/rtl/tun_pkg.sv
// shared widths and types for the triangle unit normal block
`default_nettype none
package tun_pkg;

  localparam int CoordW   = 16;                 // input coordinate, Q7.8
  localparam int DiffW    = CoordW + 1;         // edge vector component
  localparam int ProdW    = 2 * DiffW;          // edge product
  localparam int CrossW   = ProdW + 1;          // signed cross component
  localparam int MagW     = CrossW - 1;         // cross magnitude
  localparam int HalfW    = (MagW + 1) / 2;     // squaring split
  localparam int HalfPW   = 2 * HalfW;          // partial product
  localparam int SqW      = 2 * MagW;           // squared magnitude
  localparam int SumW     = SqW + 2;            // squared length
  localparam int FracBits = 14;                 // Q1.14 output
  localparam int AccW     = SqW + 2 * FracBits + 2;  // remainder / test width
  localparam int QW       = FracBits + 1;       // result magnitude
  localparam int NumSteps = QW;                 // one result bit per stage
  localparam int OutW     = 16;
  localparam int NumComp  = 3;

  // payload handed from the cross-product front to the normalizer
  typedef struct packed {
    logic                              deg;
    logic [NumComp-1:0]                neg;
    logic [SumW-1:0]                   s;
    logic [NumComp-1:0][AccW-1:0]      rem;
  } tun_front_t;

  // one finished result
  typedef struct packed {
    logic signed [OutW-1:0] nx;
    logic signed [OutW-1:0] ny;
    logic signed [OutW-1:0] nz;
    logic                   degenerate;
  } tun_result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tun_tri_if.sv
// triangle request channel
`default_nettype none
interface tun_tri_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] ax;
  logic signed [15:0] ay;
  logic signed [15:0] az;
  logic signed [15:0] bx;
  logic signed [15:0] by;
  logic signed [15:0] bz;
  logic signed [15:0] cx;
  logic signed [15:0] cy;
  logic signed [15:0] cz;
  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tun_norm_if.sv
// normal result channel
`default_nettype none
interface tun_norm_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] nx;
  logic signed [15:0] ny;
  logic signed [15:0] nz;
  logic               degenerate;
  modport source (output valid, nx, ny, nz, degenerate, input ready);
  modport sink (input valid, nx, ny, nz, degenerate, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tun_front.sv
// edge vectors, cross product, squared magnitudes and squared length
`default_nettype none
module tun_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic signed [tun_pkg::CoordW-1:0] ax,
  input  wire logic signed [tun_pkg::CoordW-1:0] ay,
  input  wire logic signed [tun_pkg::CoordW-1:0] az,
  input  wire logic signed [tun_pkg::CoordW-1:0] bx,
  input  wire logic signed [tun_pkg::CoordW-1:0] by,
  input  wire logic signed [tun_pkg::CoordW-1:0] bz,
  input  wire logic signed [tun_pkg::CoordW-1:0] cx,
  input  wire logic signed [tun_pkg::CoordW-1:0] cy,
  input  wire logic signed [tun_pkg::CoordW-1:0] cz,
  output logic                         out_valid,
  output tun_pkg::tun_front_t          out_data
);

  localparam int DW = tun_pkg::DiffW;
  localparam int PW = tun_pkg::ProdW;
  localparam int KW = tun_pkg::CrossW;
  localparam int MW = tun_pkg::MagW;
  localparam int HW = tun_pkg::HalfW;
  localparam int HPW = tun_pkg::HalfPW;
  localparam int QW2 = tun_pkg::SqW;
  localparam int NC = tun_pkg::NumComp;

  logic [5:0] v;

  // stage 1: edge vectors
  logic signed [DW-1:0] ux, uy, uz, vx, vy, vz;
  // stage 2: products
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  // stage 3: cross magnitudes and signs
  logic [NC-1:0][MW-1:0] mag;
  logic [NC-1:0]         neg3;
  // stage 4: partial squares
  logic [NC-1:0][HPW-1:0] hh, hl, ll;
  logic [NC-1:0]          neg4;
  // stage 5: full squares
  logic [NC-1:0][QW2-1:0] sq;
  logic [NC-1:0]          neg5;

  logic signed [KW-1:0] k_comb [NC];

  // cross components from the stored products
  always_comb begin
    k_comb[0] = KW'(p0) - KW'(p1);
    k_comb[1] = KW'(p2) - KW'(p3);
    k_comb[2] = KW'(p4) - KW'(p5);
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      ux <= DW'(bx) - DW'(ax);
      uy <= DW'(by) - DW'(ay);
      uz <= DW'(bz) - DW'(az);
      vx <= DW'(cx) - DW'(ax);
      vy <= DW'(cy) - DW'(ay);
      vz <= DW'(cz) - DW'(az);

      p0 <= uy * vz;
      p1 <= uz * vy;
      p2 <= uz * vx;
      p3 <= ux * vz;
      p4 <= ux * vy;
      p5 <= uy * vx;

      for (int c = 0; c < NC; c++) begin
        neg3[c] <= k_comb[c][KW-1];
        mag[c]  <= k_comb[c][KW-1] ? MW'(-k_comb[c]) : MW'(k_comb[c]);
      end

      for (int c = 0; c < NC; c++) begin
        hh[c] <= HPW'(mag[c][MW-1:HW]) * HPW'(mag[c][MW-1:HW]);
        hl[c] <= HPW'(mag[c][MW-1:HW]) * HPW'(mag[c][HW-1:0]);
        ll[c] <= HPW'(mag[c][HW-1:0]) * HPW'(mag[c][HW-1:0]);
      end
      neg4 <= neg3;

      for (int c = 0; c < NC; c++) begin
        sq[c] <= (QW2'(hh[c]) << (2 * HW)) + (QW2'(hl[c]) << (HW + 1)) + QW2'(ll[c]);
      end
      neg5 <= neg4;

      out_data.s   <= tun_pkg::SumW'(sq[0]) + tun_pkg::SumW'(sq[1])
                    + tun_pkg::SumW'(sq[2]);
      out_data.deg <= (sq[0] == '0) && (sq[1] == '0) && (sq[2] == '0);
      out_data.neg <= neg5;
      for (int c = 0; c < NC; c++) begin
        out_data.rem[c] <= tun_pkg::AccW'(sq[c]) << (2 * tun_pkg::FracBits);
      end
    end
  end

  assign out_valid = v[5];

endmodule
`default_nettype wire

FILE: hw/rtl/tun_norm.sv
// one result bit per stage: largest q with q*q*S <= c*c*2^28, then sign
`default_nettype none
module tun_norm (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  tun_pkg::tun_front_t       in_data,
  output logic                      out_valid,
  output tun_pkg::tun_result_t      out_data
);

  localparam int N  = tun_pkg::NumSteps;
  localparam int AW = tun_pkg::AccW;
  localparam int QW = tun_pkg::QW;
  localparam int NC = tun_pkg::NumComp;
  localparam int OW = tun_pkg::OutW;

  logic [N:0]                       v;
  logic [N:0]                       deg;
  logic [N:0][NC-1:0]               neg;
  logic [N:0][tun_pkg::SumW-1:0]    s;
  logic [N:0][NC-1:0][AW-1:0]       r;   // c*c*2^28 - q*q*S
  logic [N:0][NC-1:0][AW-1:0]       y;   // q*S
  logic [N:0][NC-1:0][QW-1:0]       q;

  assign v[0]   = in_valid;
  assign deg[0] = in_data.deg;
  assign neg[0] = in_data.neg;
  assign s[0]   = in_data.s;
  assign r[0]   = in_data.rem;
  assign y[0]   = '0;
  assign q[0]   = '0;

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int B = N - 1 - j;
    logic [NC-1:0][AW-1:0] t;
    logic [NC-1:0]         take;

    // trial: (q+2^B)^2*S - q^2*S = 2^(B+1)*q*S + 2^(2B)*S
    always_comb begin
      for (int c = 0; c < NC; c++) begin
        t[c]    = (y[j][c] << (B + 1)) + (AW'(s[j]) << (2 * B));
        take[c] = (t[c] <= r[j][c]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        deg[j+1] <= deg[j];
        neg[j+1] <= neg[j];
        s[j+1]   <= s[j];
        for (int c = 0; c < NC; c++) begin
          if (take[c]) begin
            r[j+1][c] <= r[j][c] - t[c];
            y[j+1][c] <= y[j][c] + (AW'(s[j]) << B);
            q[j+1][c] <= q[j][c] | (QW'(1) << B);
          end else begin
            r[j+1][c] <= r[j][c];
            y[j+1][c] <= y[j][c];
            q[j+1][c] <= q[j][c];
          end
        end
      end
    end
  end

  logic signed [OW-1:0] comp [NC];

  // apply sign, zero vector on degenerate
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      if (deg[N]) begin
        comp[c] = '0;
      end else if (neg[N][c]) begin
        comp[c] = -OW'(q[N][c]);
      end else begin
        comp[c] = OW'(q[N][c]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.nx         <= comp[0];
      out_data.ny         <= comp[1];
      out_data.nz         <= comp[2];
      out_data.degenerate <= deg[N];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/triangle_unit_normal_top.sv
// top level of the triangle unit normal pipeline
// Takes one triangle per cycle and returns its unit face normal in signed Q1.14:
// six stages form the edge vectors, cross product and squared
// length, fifteen stages each settle one bit of the component magnitudes by an
// add-compare-subtract on a 98-bit remainder, and one stage is the output
// register. The pipeline moves as a whole; when a result waits unclaimed the
// pipeline holds and the request side sees ready low, otherwise a new request
// is taken every cycle. A triangle with zero cross product returns a zero
// vector with degenerate set. No reset of payload registers is needed.
`default_nettype none
module triangle_unit_normal_top (
  input  wire logic  clk,
  input  wire logic  rst,
  tun_tri_if.sink    tri_in,
  tun_norm_if.source norm_out
);

  logic                 en;
  logic                 front_valid;
  tun_pkg::tun_front_t  front_data;
  logic                 res_valid;
  tun_pkg::tun_result_t res_data;

  // whole pipeline advances unless a result is held
  assign en           = !res_valid || norm_out.ready;
  assign tri_in.ready = en;

  tun_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (tri_in.valid),
    .ax        (tri_in.ax),
    .ay        (tri_in.ay),
    .az        (tri_in.az),
    .bx        (tri_in.bx),
    .by        (tri_in.by),
    .bz        (tri_in.bz),
    .cx        (tri_in.cx),
    .cy        (tri_in.cy),
    .cz        (tri_in.cz),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  tun_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (res_valid),
    .out_data  (res_data)
  );

  assign norm_out.valid      = res_valid;
  assign norm_out.nx         = res_data.nx;
  assign norm_out.ny         = res_data.ny;
  assign norm_out.nz         = res_data.nz;
  assign norm_out.degenerate = res_data.degenerate;

endmodule
`default_nettype wire

FILE: hw/rtl/tun_checker.sv
// port-level checks for the triangle unit normal block, bound to the top level
`default_nettype none
module tun_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] nx,
  input wire logic signed [15:0] ny,
  input wire logic signed [15:0] nz,
  input wire logic               degenerate
);

  // held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(nx) && $stable(ny) && $stable(nz)
      && $stable(degenerate))
    else $error("result changed while stalled");

  // degenerate gives the zero vector
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> nx == 16'sd0 && ny == 16'sd0 && nz == 16'sd0)
    else $error("degenerate result not zero");

  // components stay within unit range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> nx <= 16'sd16384 && nx >= -16'sd16384 && ny <= 16'sd16384
      && ny >= -16'sd16384 && nz <= 16'sd16384 && nz >= -16'sd16384)
    else $error("component out of range");

  // no result straight out of reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind triangle_unit_normal_top tun_checker u_tun_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (norm_out.valid),
  .out_ready  (norm_out.ready),
  .nx         (norm_out.nx),
  .ny         (norm_out.ny),
  .nz         (norm_out.nz),
  .degenerate (norm_out.degenerate)
);
`default_nettype wire
